// ===== src/ists_pkg.sv =====
// Shared types and constants for the sorted table with search.
// Used by the controller, the datapath, the top level and the port checker.
`default_nettype none
package ists_pkg;

  localparam int unsigned TABLE_DEPTH = 32768;
  localparam int unsigned ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_QUERY  = 2'd2,
    ACT_READ   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_CMP,
    S_INS_PUT,
    S_QRY_CMP,
    S_RD_WAIT,
    S_RESP
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic    start;
    action_e act;
    logic    clear;
    logic    ins_shift;
    logic    ins_put;
    logic    qry_next;
    logic    set_found;
    logic    take_elem;
    logic    load_out;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic count_zero;
    logic full;
    logic idx_ok;
    logic gt;
    logic eq;
    logic pos_one;
    logic last;
  } dp_stat_t;

endpackage
`default_nettype wire

// ===== src/ists_ctrl.sv =====
// Controller state machine for the sorted table: sequences clear, insert, query and read.
// Depends on ists_pkg; drives the datapath by command struct only.
`default_nettype none
module ists_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [1:0]         action_i,
  input  wire logic               out_ready_i,
  output logic                    out_valid_o,
  input  wire ists_pkg::dp_stat_t stat_i,
  output ists_pkg::ctrl_cmd_t     cmd_o
);
  import ists_pkg::*;

  state_e  state_q, state_d;
  logic    out_valid_q, out_valid_d;
  action_e act;

  assign act = action_e'(action_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    cmd_o.act   = act;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          case (act)
            ACT_CLEAR: begin
              cmd_o.clear = 1'b1;
              state_d     = S_RESP;
            end
            ACT_INSERT: begin
              if (stat_i.full) begin
                state_d = S_RESP;
              end else if (stat_i.count_zero) begin
                state_d = S_INS_PUT;
              end else begin
                state_d = S_INS_CMP;
              end
            end
            ACT_QUERY: begin
              state_d = stat_i.count_zero ? S_RESP : S_QRY_CMP;
            end
            default: begin
              state_d = stat_i.idx_ok ? S_RD_WAIT : S_RESP;
            end
          endcase
        end
      end
      S_INS_CMP: begin
        if (stat_i.gt) begin
          // move the larger entry one place right and look one further left
          cmd_o.ins_shift = 1'b1;
          if (stat_i.pos_one) begin
            state_d = S_INS_PUT;
          end
        end else begin
          cmd_o.ins_put = 1'b1;
          state_d       = S_RESP;
        end
      end
      S_INS_PUT: begin
        cmd_o.ins_put = 1'b1;
        state_d       = S_RESP;
      end
      S_QRY_CMP: begin
        if (stat_i.eq) begin
          cmd_o.set_found = 1'b1;
          state_d         = S_RESP;
        end else if (stat_i.last) begin
          state_d = S_RESP;
        end else begin
          cmd_o.qry_next = 1'b1;
        end
      end
      S_RD_WAIT: begin
        cmd_o.take_elem = 1'b1;
        state_d         = S_RESP;
      end
      S_RESP: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

// ===== src/ists_dpath.sv =====
// Datapath for the sorted table: entry memory, position and fill counters, result registers.
// Depends on ists_pkg; steered by the controller's command struct.
`default_nettype none
module ists_dpath (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic signed [31:0]  value_i,
  input  wire logic [14:0]         index_i,
  input  wire ists_pkg::ctrl_cmd_t cmd_i,
  output ists_pkg::dp_stat_t       stat_o,
  output logic [1:0]               status_o,
  output logic                     found_o,
  output logic signed [31:0]       element_o,
  output logic [15:0]              entry_total_o
);
  import ists_pkg::*;

  logic signed [31:0] mem [TABLE_DEPTH];
  logic signed [31:0] rdata_q;
  logic [ADDR_W-1:0]  rd_addr;
  logic               we;
  logic signed [31:0] wdata;

  logic [CNT_W-1:0]   pos_q, pos_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [CNT_W-1:0]   count_m1, pos_m1, pos_m2, pos_p1;
  logic signed [31:0] value_q;

  status_e            res_status_q, res_status_d;
  logic               res_found_q, res_found_d;
  logic signed [31:0] res_elem_q, res_elem_d;

  status_e            out_status_q;
  logic               out_found_q;
  logic signed [31:0] out_elem_q;
  logic [15:0]        out_total_q;

  assign count_m1 = count_q - CNT_W'(1);
  assign pos_m1   = pos_q - CNT_W'(1);
  assign pos_m2   = pos_q - CNT_W'(2);
  assign pos_p1   = pos_q + CNT_W'(1);

  assign stat_o.count_zero = (count_q == '0);
  assign stat_o.full       = (count_q == CNT_W'(TABLE_DEPTH));
  assign stat_o.idx_ok     = (32'(index_i) < 32'(count_q));
  assign stat_o.gt         = (rdata_q > value_q);
  assign stat_o.eq         = (rdata_q == value_q);
  assign stat_o.pos_one    = (pos_q == CNT_W'(1));
  assign stat_o.last       = (pos_p1 >= count_q);

  // read address for the entry needed in the next cycle
  always_comb begin
    rd_addr = pos_q[ADDR_W-1:0];
    if (cmd_i.start) begin
      case (cmd_i.act)
        ACT_INSERT: rd_addr = count_m1[ADDR_W-1:0];
        ACT_READ:   rd_addr = ADDR_W'(index_i);
        default:    rd_addr = '0;
      endcase
    end else if (cmd_i.ins_shift) begin
      rd_addr = pos_m2[ADDR_W-1:0];
    end else if (cmd_i.qry_next) begin
      rd_addr = pos_p1[ADDR_W-1:0];
    end
  end

  assign we    = cmd_i.ins_shift | cmd_i.ins_put;
  assign wdata = cmd_i.ins_shift ? rdata_q : value_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[pos_q[ADDR_W-1:0]] <= wdata;
    end
    rdata_q <= mem[rd_addr];
  end

  always_comb begin
    pos_d        = pos_q;
    count_d      = count_q;
    res_status_d = res_status_q;
    res_found_d  = res_found_q;
    res_elem_d   = res_elem_q;
    if (cmd_i.start) begin
      pos_d        = (cmd_i.act == ACT_INSERT) ? count_q : '0;
      res_found_d  = 1'b0;
      res_elem_d   = '0;
      res_status_d = ST_OK;
      if (cmd_i.act == ACT_INSERT && stat_o.full) begin
        res_status_d = ST_FULL;
      end else if (cmd_i.act == ACT_READ && !stat_o.idx_ok) begin
        res_status_d = ST_RANGE;
      end
    end
    if (cmd_i.clear) begin
      count_d = '0;
    end
    if (cmd_i.ins_shift) begin
      pos_d = pos_m1;
    end
    if (cmd_i.ins_put) begin
      count_d = count_q + CNT_W'(1);
    end
    if (cmd_i.qry_next) begin
      pos_d = pos_p1;
    end
    if (cmd_i.set_found) begin
      res_found_d = 1'b1;
    end
    if (cmd_i.take_elem) begin
      res_elem_d = rdata_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q        <= pos_d;
    res_status_q <= res_status_d;
    res_found_q  <= res_found_d;
    res_elem_q   <= res_elem_d;
    if (cmd_i.start) begin
      value_q <= value_i;
    end
    if (cmd_i.load_out) begin
      out_status_q <= res_status_q;
      out_found_q  <= res_found_q;
      out_elem_q   <= res_elem_q;
      out_total_q  <= 16'(count_q);
    end
  end

  assign status_o      = out_status_q;
  assign found_o       = out_found_q;
  assign element_o     = out_elem_q;
  assign entry_total_o = out_total_q;

endmodule
`default_nettype wire

// ===== src/insertion_sorted_table_with_search.sv =====
// Top level of the sorted table with insert, membership query and indexed read.
// Depends on ists_pkg, ists_ctrl and ists_dpath.
//
// One request is taken at a time; the next is taken as soon as the previous one has
// been placed in the output register, even while that result waits to be taken. An
// insert into a full table is dropped; an insert walks over each larger entry and a query
// over each entry up to a hit or the last one, their time set by the single read port of
// the entry memory, which delivers one entry per cycle. The memory needs no clearing
// pass: only entries below the fill count are ever used.
`default_nettype none
module insertion_sorted_table_with_search (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [1:0]         action_i,
  input  wire logic signed [31:0] value_i,
  input  wire logic [14:0]        index_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [1:0]              status_o,
  output logic                    found_o,
  output logic signed [31:0]      element_o,
  output logic [15:0]             entry_total_o
);
  import ists_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  ists_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .action_i    (action_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  ists_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .value_i       (value_i),
    .index_i       (index_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .status_o      (status_o),
    .found_o       (found_o),
    .element_o     (element_o),
    .entry_total_o (entry_total_o)
  );

endmodule
`default_nettype wire

// ===== src/ists_checker.sv =====
// Port-level checker for the sorted table, bound to the top level.
// Depends on ists_pkg for status codes and the table depth.
`default_nettype none
module ists_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire logic [1:0]         status_o,
  input wire logic               found_o,
  input wire logic signed [31:0] element_o,
  input wire logic [15:0]        entry_total_o
);
  import ists_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) && $stable(found_o)
      && $stable(element_o) && $stable(entry_total_o))
    else $error("result changed while stalled");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o != 2'd3)
    else $error("undefined status code");

  // a hit only comes from a query, which never carries an element
  a_found_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && found_o |-> status_o == ST_OK && element_o == '0)
    else $error("found flag with bad status or element");

  a_range_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_RANGE |-> element_o == '0 && !found_o)
    else $error("range error carries data");

  a_full_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_FULL |-> entry_total_o == 16'(TABLE_DEPTH) && !found_o)
    else $error("full status with table not full");

endmodule

bind insertion_sorted_table_with_search ists_checker u_ists_checker (.*);
`default_nettype wire

// ===== bench/tb_insertion_sorted_table_with_search.sv =====
// Testbench for the sorted table: sends clear, insert, query and read requests
// with random handshake gaps and checks each reply against a behavioural table.
// Depends on ists_pkg and insertion_sorted_table_with_search.

typedef struct packed {
  ists_pkg::status_e   status;
  logic                found;
  logic signed [31:0]  element;
  logic [15:0]         entry_total;
} table_reply_t;

class table_scoreboard;
  logic signed [31:0] entries[$];
  table_reply_t       replies_due[$];
  int unsigned        mismatches = 0;

  // Update the table copy for an accepted request and queue its reply.
  function void note_request(ists_pkg::action_e act, logic signed [31:0] val,
                             logic [14:0] idx);
    table_reply_t r;
    int unsigned  pos;
    int unsigned  held;
    r.status  = ists_pkg::ST_OK;
    r.found   = 1'b0;
    r.element = '0;
    case (act)
      ists_pkg::ACT_CLEAR: entries.delete();
      ists_pkg::ACT_INSERT: begin
        if (entries.size() >= ists_pkg::TABLE_DEPTH) begin
          r.status = ists_pkg::ST_FULL;
        end else begin
          pos = entries.size();
          // equal entries stay in front of the new one
          while (pos > 0 && entries[pos-1] > val) pos--;
          entries.insert(pos, val);
        end
      end
      ists_pkg::ACT_QUERY: begin
        foreach (entries[i]) if (entries[i] == val) r.found = 1'b1;
      end
      default: begin
        if (idx < entries.size()) r.element = entries[idx];
        else r.status = ists_pkg::ST_RANGE;
      end
    endcase
    held = entries.size();
    r.entry_total = held[15:0];
    replies_due.push_back(r);
  endfunction

  function void check_reply(logic [1:0] st, logic fnd, logic signed [31:0] elem,
                            logic [15:0] total);
    table_reply_t r;
    if (replies_due.size() == 0) begin
      $display("%0t: reply with nothing pending: status %0d found %0d element %0d total %0d",
               $time, st, fnd, elem, total);
      mismatches++;
      return;
    end
    r = replies_due.pop_front();
    if (st !== r.status) begin
      $display("%0t: status mismatch, expected %0d, actual %0d", $time, r.status, st);
      mismatches++;
    end
    if (fnd !== r.found) begin
      $display("%0t: found mismatch, expected %0d, actual %0d", $time, r.found, fnd);
      mismatches++;
    end
    if (elem !== r.element) begin
      $display("%0t: element mismatch, expected %0d, actual %0d", $time, r.element, elem);
      mismatches++;
    end
    if (total !== r.entry_total) begin
      $display("%0t: entry_total mismatch, expected %0d, actual %0d",
               $time, r.entry_total, total);
      mismatches++;
    end
  endfunction
endclass

module tb_insertion_sorted_table_with_search;
  import ists_pkg::*;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [1:0]         action_i;
  logic signed [31:0] value_i;
  logic [14:0]        index_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [1:0]         status_o;
  logic               found_o;
  logic signed [31:0] element_o;
  logic [15:0]        entry_total_o;

  table_scoreboard sb = new();
  bit              quiet = 1'b0;
  int              replies_seen = 0;

  insertion_sorted_table_with_search dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .action_i      (action_i),
    .value_i       (value_i),
    .index_i       (index_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .found_o       (found_o),
    .element_o     (element_o),
    .entry_total_o (entry_total_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    #30_000_000;
    $display("status: fail");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_reply(status_o, found_o, element_o, entry_total_o);
      replies_seen++;
    end
  end

  // Reply side: random stalls, plus one long hold to back the block up.
  initial begin
    int burst;
    bit long_hold_done;
    burst = 0;
    long_hold_done = 1'b0;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!long_hold_done && replies_seen >= 30) begin
        long_hold_done = 1'b1;
        burst = 400;
      end
      if (burst > 0) begin
        out_ready_i = 1'b0;
        burst--;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ready_i = 1'b0;
        burst = $urandom_range(1, 12) - 1;
      end else begin
        out_ready_i = 1'b1;
      end
    end
  end

  task automatic send_request(input action_e act, input logic signed [31:0] val,
                              input logic [14:0] idx);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 12);
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i = 1'b1;
    action_i   = act;
    value_i    = val;
    index_i    = idx;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_request(act, val, idx);
  endtask

  initial begin
    int                 i;
    int                 pick;
    int                 held;
    action_e            act;
    logic signed [31:0] val;
    logic [14:0]        idx;

    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    action_i   = ACT_CLEAR;
    value_i    = '0;
    index_i    = '0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: empty table, extremes, duplicates, out-of-range reads, clear
    send_request(ACT_READ,   0, 0);
    send_request(ACT_QUERY,  0, 0);
    send_request(ACT_INSERT, 0, 0);
    send_request(ACT_INSERT, 32'sh8000_0000, 0);
    send_request(ACT_INSERT, 32'sh7fff_ffff, 0);
    send_request(ACT_INSERT, 5, 0);
    send_request(ACT_INSERT, 5, 0);
    send_request(ACT_INSERT, -1, 0);
    send_request(ACT_READ,   0, 0);
    send_request(ACT_READ,   0, 1);
    send_request(ACT_READ,   0, 5);
    send_request(ACT_READ,   0, 6);
    send_request(ACT_READ,   0, 15'h7fff);
    send_request(ACT_QUERY,  32'sh8000_0000, 0);
    send_request(ACT_QUERY,  32'sh7fff_ffff, 0);
    send_request(ACT_QUERY,  5, 0);
    send_request(ACT_QUERY,  4, 0);
    send_request(ACT_QUERY,  -1, 0);
    send_request(ACT_CLEAR,  32'sh7fff_ffff, 15'h7fff);
    send_request(ACT_READ,   0, 0);
    send_request(ACT_QUERY,  0, 0);
    send_request(ACT_INSERT, -7, 0);
    send_request(ACT_READ,   0, 0);
    send_request(ACT_INSERT, 3, 0);

    for (i = 0; i < 70; i++) begin
      // hold the next request until every reply is back
      if (i == 35) begin
        @(negedge clk_i);
        in_valid_i = 1'b0;
        while (sb.replies_due.size() != 0) @(negedge clk_i);
      end
      quiet = (i >= 55);
      pick = $urandom_range(0, 99);
      act = (pick < 4) ? ACT_CLEAR : (pick < 50) ? ACT_INSERT :
            (pick < 75) ? ACT_QUERY : ACT_READ;
      held = sb.entries.size();
      case ($urandom_range(0, 3))
        0: val = $urandom();
        1: val = int'($urandom_range(0, 15)) - 8;
        2: begin
          case ($urandom_range(0, 3))
            0:       val = 32'sh8000_0000;
            1:       val = 32'sh7fff_ffff;
            2:       val = -1;
            default: val = 0;
          endcase
        end
        default: val = (held > 0) ? sb.entries[$urandom_range(0, held - 1)] : $urandom();
      endcase
      case ($urandom_range(0, 3))
        0, 1:    idx = (held > 0) ? 15'($urandom_range(0, held - 1)) : '0;
        2:       idx = 15'(held + $urandom_range(0, 2));
        default: idx = 15'($urandom());
      endcase
      send_request(act, val, idx);
    end

    quiet = 1'b1;
    send_request(ACT_CLEAR,  0, 0);
    send_request(ACT_READ,   0, 0);

    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.replies_due.size() != 0) @(negedge clk_i);
    repeat (40) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.replies_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
